[src/i2cme_pkg.sv]
// Shared types, command codes and helpers for the I2C master byte engine.
package i2cme_pkg;

	// Stream payload widths; the tdata widths are padded to whole bytes
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 16;

	// Configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 8;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_TICK_SCALE  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ACK_TIMEOUT = 1'd1;

	// Register reset values
	localparam logic [7:0] TICK_SCALE_RST  = 8'd1;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	// Command codes; unused codes behave as a tick
	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_START    = 3'd1;
	localparam logic [2:0] CMD_STOP     = 3'd2;
	localparam logic [2:0] CMD_WRITE    = 3'd3;
	localparam logic [2:0] CMD_READ     = 3'd4;
	localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

	// Delay lengths in microsecond units
	localparam logic [2:0] UNITS_LONG  = 3'd4;
	localparam logic [2:0] UNITS_HALF  = 3'd2;
	localparam logic [2:0] UNITS_SHORT = 3'd1;

	// Last bit index of a byte
	localparam logic [2:0] LAST_BIT = 3'd7;

	// Sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_ST_A = 4'd1,
		PH_ST_B = 4'd2,
		PH_SP_A = 4'd3,
		PH_SP_B = 4'd4,
		PH_WA_A = 4'd5,
		PH_WA_B = 4'd6,
		PH_WA_P = 4'd7,
		PH_WR_A = 4'd8,
		PH_WR_B = 4'd9,
		PH_WR_C = 4'd10,
		PH_RD_A = 4'd11,
		PH_RD_B = 4'd12,
		PH_AK_A = 4'd13,
		PH_AK_B = 4'd14
	} phase_t;

	// One result item
	typedef struct packed {
		logic       rejected;
		logic       ack_failed;
		logic [7:0] read_data;
		logic       done_res;
		logic       sda_level;
		logic       scl_level;
	} res_t;

	// Delay length in ticks: units times the tick scale, where a scale of zero counts as one
	function automatic logic [9:0] wait_ticks(input logic [2:0] units, input logic [7:0] scale);
		logic [7:0] s;
		begin
			s = (scale == 8'd0) ? 8'd1 : scale;
			wait_ticks = 10'({7'd0, units} * {2'd0, s});
		end
	endfunction

endpackage

[src/i2cme_seq.sv]
// Pin sequencer: phase state, counters and the next-state logic for one item.
module i2cme_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [2:0]          command,
	input  logic [7:0]          data_byte,
	input  logic                send_ack,
	input  logic                sda_sample,
	input  logic [7:0]          tick_scale,
	input  logic [7:0]          ack_timeout_limit,
	output i2cme_pkg::res_t     res
);
	import i2cme_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] active_op_q, active_op_d;
	logic [2:0] bit_count_q, bit_count_d;
	logic [7:0] shift_byte_q, shift_byte_d;
	logic [9:0] delay_count_q, delay_count_d;
	logic [7:0] timeout_count_q, timeout_count_d;
	logic       ack_choice_q, ack_choice_d;
	logic       scl_out_q, scl_out_d;
	logic       sda_out_q, sda_out_d;
	logic [7:0] read_reg_q, read_reg_d;
	logic       fail_flag_q, fail_flag_d;
	logic       done, rej;
	logic [9:0] dec;

	// Next state for the item at hand
	always_comb begin
		phase_d         = phase_q;
		active_op_d     = active_op_q;
		bit_count_d     = bit_count_q;
		shift_byte_d    = shift_byte_q;
		delay_count_d   = delay_count_q;
		timeout_count_d = timeout_count_q;
		ack_choice_d    = ack_choice_q;
		scl_out_d       = scl_out_q;
		sda_out_d       = sda_out_q;
		read_reg_d      = read_reg_q;
		fail_flag_d     = fail_flag_q;
		done            = 1'b0;
		rej             = 1'b0;
		dec             = (delay_count_q == 10'd0) ? 10'd0 : delay_count_q - 10'd1;

		if (command inside {[CMD_START:CMD_WAIT_ACK]}) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				// Start a new command sequence
				active_op_d     = command;
				fail_flag_d     = 1'b0;
				bit_count_d     = 3'd0;
				timeout_count_d = 8'd0;
				case (command)
					CMD_START: begin
						sda_out_d     = 1'b1;
						scl_out_d     = 1'b1;
						phase_d       = PH_ST_A;
						delay_count_d = wait_ticks(UNITS_LONG, tick_scale);
					end
					CMD_STOP: begin
						scl_out_d     = 1'b0;
						sda_out_d     = 1'b0;
						phase_d       = PH_SP_A;
						delay_count_d = wait_ticks(UNITS_LONG, tick_scale);
					end
					CMD_WRITE: begin
						scl_out_d     = 1'b0;
						sda_out_d     = data_byte[7];
						shift_byte_d  = {data_byte[6:0], 1'b0};
						phase_d       = PH_WR_A;
						delay_count_d = wait_ticks(UNITS_HALF, tick_scale);
					end
					CMD_READ: begin
						ack_choice_d  = send_ack;
						shift_byte_d  = 8'd0;
						scl_out_d     = 1'b0;
						sda_out_d     = 1'b1;
						phase_d       = PH_RD_A;
						delay_count_d = wait_ticks(UNITS_HALF, tick_scale);
					end
					default: begin
						sda_out_d     = 1'b1;
						phase_d       = PH_WA_A;
						delay_count_d = wait_ticks(UNITS_SHORT, tick_scale);
					end
				endcase
			end
		end else if (phase_q == PH_WA_P) begin
			// Poll for the slave ACK; on a timeout, begin a STOP sequence
			if (!sda_sample) begin
				scl_out_d = 1'b0;
				phase_d   = PH_IDLE;
				done      = 1'b1;
			end else if (timeout_count_q >= ack_timeout_limit) begin
				scl_out_d     = 1'b0;
				sda_out_d     = 1'b0;
				phase_d       = PH_SP_A;
				delay_count_d = wait_ticks(UNITS_LONG, tick_scale);
			end else begin
				timeout_count_d = timeout_count_q + 8'd1;
			end
		end else if (phase_q != PH_IDLE) begin
			// Count down the delay and step the sequence when it runs out
			delay_count_d = dec;
			if (dec == 10'd0) begin
				case (phase_q)
					PH_ST_A: begin
						sda_out_d     = 1'b0;
						phase_d       = PH_ST_B;
						delay_count_d = wait_ticks(UNITS_LONG, tick_scale);
					end
					PH_ST_B: begin
						scl_out_d = 1'b0;
						phase_d   = PH_IDLE;
						done      = 1'b1;
					end
					PH_SP_A: begin
						scl_out_d     = 1'b1;
						sda_out_d     = 1'b1;
						phase_d       = PH_SP_B;
						delay_count_d = wait_ticks(UNITS_LONG, tick_scale);
					end
					PH_SP_B: begin
						if (active_op_q == CMD_WAIT_ACK) begin
							fail_flag_d = 1'b1;
						end
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
					PH_WA_A: begin
						scl_out_d     = 1'b1;
						phase_d       = PH_WA_B;
						delay_count_d = wait_ticks(UNITS_SHORT, tick_scale);
					end
					PH_WA_B: begin
						phase_d         = PH_WA_P;
						timeout_count_d = 8'd0;
					end
					PH_WR_A: begin
						scl_out_d     = 1'b1;
						phase_d       = PH_WR_B;
						delay_count_d = wait_ticks(UNITS_HALF, tick_scale);
					end
					PH_WR_B: begin
						scl_out_d     = 1'b0;
						phase_d       = PH_WR_C;
						delay_count_d = wait_ticks(UNITS_HALF, tick_scale);
					end
					PH_WR_C: begin
						if (bit_count_q < LAST_BIT) begin
							bit_count_d   = bit_count_q + 3'd1;
							sda_out_d     = shift_byte_q[7];
							shift_byte_d  = {shift_byte_q[6:0], 1'b0};
							phase_d       = PH_WR_A;
							delay_count_d = wait_ticks(UNITS_HALF, tick_scale);
						end else begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
					end
					PH_RD_A: begin
						// SCL rises and the data bit is sampled
						phase_d       = PH_RD_B;
						delay_count_d = wait_ticks(UNITS_SHORT, tick_scale);
						scl_out_d     = 1'b1;
						shift_byte_d  = {shift_byte_q[6:0], sda_sample};
					end
					PH_RD_B: begin
						scl_out_d = 1'b0;
						if (bit_count_q < LAST_BIT) begin
							bit_count_d   = bit_count_q + 3'd1;
							phase_d       = PH_RD_A;
							delay_count_d = wait_ticks(UNITS_HALF, tick_scale);
						end else begin
							sda_out_d     = !ack_choice_q;
							phase_d       = PH_AK_A;
							delay_count_d = wait_ticks(UNITS_HALF, tick_scale);
						end
					end
					PH_AK_A: begin
						scl_out_d     = 1'b1;
						phase_d       = PH_AK_B;
						delay_count_d = wait_ticks(UNITS_HALF, tick_scale);
					end
					PH_AK_B: begin
						scl_out_d  = 1'b0;
						read_reg_d = shift_byte_q;
						phase_d    = PH_IDLE;
						done       = 1'b1;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end

		res.scl_level  = scl_out_d;
		res.sda_level  = sda_out_d;
		res.done_res   = done;
		res.read_data  = read_reg_d;
		res.ack_failed = fail_flag_d;
		res.rejected   = rej;
	end

	// Commit the state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			active_op_q     <= 3'd0;
			bit_count_q     <= 3'd0;
			shift_byte_q    <= 8'd0;
			delay_count_q   <= 10'd0;
			timeout_count_q <= 8'd0;
			ack_choice_q    <= 1'b0;
			scl_out_q       <= 1'b1;
			sda_out_q       <= 1'b1;
			read_reg_q      <= 8'd0;
			fail_flag_q     <= 1'b0;
		end else if (step_en) begin
			phase_q         <= phase_d;
			active_op_q     <= active_op_d;
			bit_count_q     <= bit_count_d;
			shift_byte_q    <= shift_byte_d;
			delay_count_q   <= delay_count_d;
			timeout_count_q <= timeout_count_d;
			ack_choice_q    <= ack_choice_d;
			scl_out_q       <= scl_out_d;
			sda_out_q       <= sda_out_d;
			read_reg_q      <= read_reg_d;
			fail_flag_q     <= fail_flag_d;
		end
	end

endmodule

[src/i2c_master_byte_engine_core.sv]
// Top level: stream handshake, configuration registers and result register.
// An accepted item's result is registered and shows on m_tdata in the next cycle.
// One item per cycle unless m_tready stalls; sequencer state updates on accept.
// The single result register frees itself in the cycle the result is taken.
// Reset: arst_n clears the sequencer to idle with both pins released high,
// tick_scale to 1, ack_timeout_limit to 250, and empties the result register.
module i2c_master_byte_engine_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input item stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [i2cme_pkg::IN_TDATA_W-1:0]     s_tdata,  // data_byte, send_ack, sda_sample
	input  logic [i2cme_pkg::IN_TUSER_W-1:0]     s_tuser,  // command
	// Result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// scl_level, sda_level, done_res, read_data, ack_failed, rejected
	output logic [i2cme_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// Configuration writes
	input  logic                                 cfg_we,
	input  logic [i2cme_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [i2cme_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import i2cme_pkg::*;

	logic       accept;
	logic [7:0] tick_scale_q;
	logic [7:0] ack_timeout_q;
	res_t       res;
	logic       out_valid_q;
	res_t       out_res_q;

	// Take a new item whenever the result register is empty or being drained
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_scale_q  <= TICK_SCALE_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TICK_SCALE:  tick_scale_q  <= cfg_wdata;
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	i2cme_seq u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.step_en           (accept),
		.command           (s_tuser[2:0]),
		.data_byte         (s_tdata[7:0]),
		.send_ack          (s_tdata[8]),
		.sda_sample        (s_tdata[9]),
		.tick_scale        (tick_scale_q),
		.ack_timeout_limit (ack_timeout_q),
		.res               (res)
	);

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_res_q};

endmodule
